[sv/humidity_temp_frame_decoder_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature frame decoder
// Shorthands for concurrent checks clocked on clock and disabled in reset.
// The module that uses them must have signals named clock and reset.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define HTFD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

[sv/htfd_pkg.sv]
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types and constants of the readout frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

   // CRC-8 over each two-byte word, MSB first
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // conversion scale factors, full scale divides by 2^16 - 1
   localparam logic [14:0] TEMP_SCALE    = 15'd17500;
   localparam logic [13:0] HUM_SCALE     = 14'd10000;
   localparam logic [16:0] SCALE_DIVISOR = 17'd65535;
   localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
   localparam logic [13:0] HUM_MAX       = 14'd10000;

   // position of the next byte within the frame
   typedef enum logic [2:0] {
      POS_T_MSB = 3'd0,
      POS_T_LSB = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_MSB = 3'd3,
      POS_H_LSB = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_CRC = 2'd1,
      STATUS_HUM_CRC  = 2'd2
   } status_type;

   // one completed frame on its way to conversion
   typedef struct packed {
      status_type  status;
      logic [30:0] temp_prod;
      logic [29:0] hum_prod;
   } htfd_stage_type;

endpackage

[sv/humidity_temp_frame_decoder_top.sv]
// Path: the frame result of the sixth byte is registered in the frame stage, then loaded into the
// output register, where it is presented and held until it is taken.
// Throughput: one byte per cycle; the frame stage and the output register form the pipeline.
// A stalled result stops new bytes only once the frame stage behind it is also full.
// Reset (synchronous, active high) restarts the count at byte 0, sets the CRC to 0xFF
// and drops any frame or result in flight.
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes six-byte sensor readouts: CRC-8 checks on both words and
// conversion to hundredths of a degree C and of a percent.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_frame_start,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi
);
   import htfd_pkg::*;

   logic           stage_valid;
   logic           stage_stall;
   htfd_stage_type stage;

   // byte sequencing and CRC checks
   htfd_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .req_data_byte   (req_data_byte),
      .stage_valid     (stage_valid),
      .stage_stall     (stage_stall),
      .stage           (stage)
   );

   // reading conversion and output register
   htfd_convert u_convert (
      .clock                 (clock),
      .reset                 (reset),
      .stage_valid           (stage_valid),
      .stage_stall           (stage_stall),
      .stage                 (stage),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi)
   );

endmodule

[sv/htfd_frame.sv]
// ----------------------------------------------------------------------------
// htfd_frame
// Byte sequencer: tracks the frame position, runs the CRC checks, collects
// both raw words and, on the last byte, registers status and scaled products.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_top_macros.svh"

module htfd_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_frame_start,
   input  logic [7:0]              req_data_byte,
   output logic                    stage_valid,
   input  logic                    stage_stall,
   output htfd_pkg::htfd_stage_type stage
);
   import htfd_pkg::*;

   pos_type        pos_ff, pos_in, eff_pos;
   logic [7:0]     crc_ff, crc_in;
   logic [15:0]    temp_raw_ff, temp_raw_in;
   logic [15:0]    hum_raw_ff, hum_raw_in;
   logic           tcrc_ok_ff, tcrc_ok_in;
   logic           s1_valid_ff, s1_valid_in;
   htfd_stage_type stage_ff, stage_in;
   logic           accept;

   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // hold new bytes only while a finished frame cannot move on
   assign req_stall = s1_valid_ff & stage_stall;
   assign accept    = req_valid & ~req_stall;

   // frame start or an out-of-range count restarts at the first byte
   assign eff_pos = (req_frame_start || pos_ff > POS_H_CRC) ? POS_T_MSB : pos_ff;

   // next position
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         case (eff_pos)
            POS_T_MSB: pos_in = POS_T_LSB;
            POS_T_LSB: pos_in = POS_T_CRC;
            POS_T_CRC: pos_in = POS_H_MSB;
            POS_H_MSB: pos_in = POS_H_LSB;
            POS_H_LSB: pos_in = POS_H_CRC;
            POS_H_CRC: pos_in = POS_T_MSB;
            default:   pos_in = POS_T_MSB;
         endcase
      end
   end

   // CRC, raw words and the frame result
   always_comb begin
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      hum_raw_in  = hum_raw_ff;
      tcrc_ok_in  = tcrc_ok_ff;
      stage_in    = stage_ff;
      s1_valid_in = s1_valid_ff & stage_stall;
      if (accept) begin
         case (eff_pos)
            POS_T_MSB: begin
               crc_in      = crc8_feed(CRC_INIT, req_data_byte);
               temp_raw_in = {req_data_byte, 8'h00};
            end
            POS_T_LSB: begin
               crc_in      = crc8_feed(crc_ff, req_data_byte);
               temp_raw_in = {temp_raw_ff[15:8], req_data_byte};
            end
            POS_T_CRC: begin
               tcrc_ok_in = (crc_ff == req_data_byte);
               crc_in     = CRC_INIT;
            end
            POS_H_MSB: begin
               crc_in     = crc8_feed(CRC_INIT, req_data_byte);
               hum_raw_in = {req_data_byte, 8'h00};
            end
            POS_H_LSB: begin
               crc_in     = crc8_feed(crc_ff, req_data_byte);
               hum_raw_in = {hum_raw_ff[15:8], req_data_byte};
            end
            POS_H_CRC: begin
               crc_in = CRC_INIT;
               if (!tcrc_ok_ff) begin
                  stage_in.status = STATUS_TEMP_CRC;
               end else if (crc_ff != req_data_byte) begin
                  stage_in.status = STATUS_HUM_CRC;
               end else begin
                  stage_in.status = STATUS_OK;
               end
               stage_in.temp_prod = 31'(TEMP_SCALE) * 31'(temp_raw_ff);
               stage_in.hum_prod  = 30'(HUM_SCALE) * 30'(hum_raw_ff);
               s1_valid_in        = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_T_MSB;
         crc_ff      <= CRC_INIT;
         tcrc_ok_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         tcrc_ok_ff  <= tcrc_ok_in;
         s1_valid_ff <= s1_valid_in;
      end
      temp_raw_ff <= temp_raw_in;
      hum_raw_ff  <= hum_raw_in;
      stage_ff    <= stage_in;
   end

   assign stage_valid = s1_valid_ff;
   assign stage       = stage_ff;

   `HTFD_ASSERT_NEXT(a_start_restarts, accept && req_frame_start, pos_ff == POS_T_LSB, "frame start did not restart the count")
   `HTFD_ASSERT_NEXT(a_last_byte_emits, accept && !req_frame_start && pos_ff == POS_H_CRC, s1_valid_ff, "last byte gave no frame result")
   `HTFD_ASSERT_NEXT(a_stage_holds, s1_valid_ff && stage_stall, s1_valid_ff && $stable(stage_ff), "stalled frame result changed")
   `HTFD_ASSERT_NEXT(a_crc_reinit, accept && eff_pos == POS_T_CRC, crc_ff == CRC_INIT, "CRC not reinitialized after check byte")

endmodule

[sv/htfd_convert.sv]
// ----------------------------------------------------------------------------
// htfd_convert
// Divides the scaled products by 2^16 - 1, applies the temperature offset and
// humidity limit, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_top_macros.svh"

module htfd_convert (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   output logic                     stage_stall,
   input  htfd_pkg::htfd_stage_type stage,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [14:0]       rsp_temperature_centi,
   output logic [13:0]              rsp_humidity_centi
);
   import htfd_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff;
   logic signed [14:0] temp_ff, temp_in;
   logic [13:0]        hum_ff, hum_in;
   logic [14:0]        tq, hq;
   logic signed [15:0] temp_wide;
   logic               load;

   // floor(p / 65535): p = q0 * 65535 + (low + q0), remainder below twice the divisor
   function automatic logic [14:0] div_65535(input logic [30:0] p);
      logic [14:0] q0;
      logic [16:0] r;
      q0 = p[30:16];
      r  = {1'b0, p[15:0]} + {2'b00, q0};
      return (r >= SCALE_DIVISOR) ? q0 + 15'd1 : q0;
   endfunction

   // hold the frame result while the output beat waits
   assign stage_stall = rsp_valid_ff & rsp_stall;
   assign load        = stage_valid & ~stage_stall;

   // convert both readings
   always_comb begin
      tq        = div_65535(stage.temp_prod);
      hq        = div_65535({1'b0, stage.hum_prod});
      temp_wide = $signed({1'b0, tq}) - TEMP_OFFSET;
      temp_in   = temp_wide[14:0];
      hum_in    = (hq > 15'(HUM_MAX)) ? HUM_MAX : hq[13:0];
   end

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         status_ff <= stage.status;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_centi    = hum_ff;

   `HTFD_ASSERT_SAME(a_hum_limit, rsp_valid_ff, hum_ff <= HUM_MAX, "humidity above full scale")
   `HTFD_ASSERT_SAME(a_temp_range, rsp_valid_ff, temp_ff <= 15'sd13000 && temp_ff >= -15'sd4500, "temperature out of range")
   `HTFD_ASSERT_NEXT(a_load_shows, load, rsp_valid_ff, "loaded result not presented")

endmodule
